[hdl/eaup_pkg.sv]
// Shared types and constants for the Ethernet ARP/UDP receive parser.
package eaup_pkg;

   // Result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_UDP     = 2'd1;
   localparam logic [1:0] KIND_ARP     = 2'd2;
   localparam logic [1:0] KIND_IGNORED = 2'd3;

   localparam logic [15:0] ET_ARP    = 16'h0806;
   localparam logic [15:0] ET_IPV4   = 16'h0800;
   localparam logic [7:0]  PROTO_UDP = 8'd17;
   localparam logic [15:0] ARP_OP_REQUEST = 16'd1;

   // Frame layout: byte offsets from the destination MAC, and header lengths
   localparam int ETH_TYPE_POS = 12;
   localparam int ETH_HDR      = 14;
   localparam int IP_MIN_HDR   = 20;
   localparam int ARP_LEN      = 28;
   localparam int UDP_HDR      = 8;

   // Result queue depth; must hold two beats behind a stalled head
   localparam int QUEUE_DEPTH  = 4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_data;
      logic [15:0] udp_dest_port;
      logic [31:0] source_ip;
      logic [11:0] payload_length;
      logic [15:0] arp_operation;
      logic [47:0] arp_sender_mac;
      logic [31:0] arp_target_ip;
      logic        reply_needed;
      logic        last;
   } rsp_type;

   // Up to two results produced by one accepted beat, in delivery order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

[hdl/eaup_parser.sv]
// Per-byte frame parser: header field capture and result generation.
module eaup_parser import eaup_pkg::*; #(
   parameter int MAX_FRAME = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output push_type    push
);

   localparam int IDX_W = $clog2(MAX_FRAME + 1);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0]      ether_kind_ff, ether_kind_in;
   logic [5:0]       header_len_ff, header_len_in;
   logic [7:0]       ip_proto_ff, ip_proto_in;
   logic [31:0]      src_addr_ff, src_addr_in;
   logic [15:0]      dst_port_ff, dst_port_in;
   logic [15:0]      udp_len_ff, udp_len_in;
   logic [15:0]      arp_oper_ff, arp_oper_in;
   logic [47:0]      sender_mac_ff, sender_mac_in;
   logic [31:0]      target_ip_ff, target_ip_in;
   logic [IDX_W-1:0] payload_count_ff, payload_count_in;
   logic [31:0]      local_ip_ff;

   logic [7:0]       b;
   logic [IDX_W-1:0] idx;
   logic [IDX_W-1:0] hdr_end;
   logic [IDX_W-1:0] u;
   logic [15:0]      cap;
   logic             payload_hit;
   rsp_type          pay_rsp;
   rsp_type          sum_rsp;

   assign b   = req_data.data_byte;
   assign idx = byte_index_ff;
   assign hdr_end = IDX_W'(header_len_ff) + IDX_W'(ETH_HDR);
   assign u       = idx - hdr_end;
   assign cap     = (udp_len_ff >= 16'(UDP_HDR)) ? udp_len_ff - 16'(UDP_HDR) : 16'd0;

   always_comb begin
      byte_index_in    = byte_index_ff;
      ether_kind_in    = ether_kind_ff;
      header_len_in    = header_len_ff;
      ip_proto_in      = ip_proto_ff;
      src_addr_in      = src_addr_ff;
      dst_port_in      = dst_port_ff;
      udp_len_in       = udp_len_ff;
      arp_oper_in      = arp_oper_ff;
      sender_mac_in    = sender_mac_ff;
      target_ip_in     = target_ip_ff;
      payload_count_in = payload_count_ff;
      payload_hit      = 1'b0;

      // bytes past the frame limit are dropped
      if (idx < IDX_W'(MAX_FRAME)) begin
         byte_index_in = idx + IDX_W'(1);
         if (idx == IDX_W'(ETH_TYPE_POS) || idx == IDX_W'(ETH_TYPE_POS + 1)) begin
            ether_kind_in = {ether_kind_ff[7:0], b};
         end else if (idx >= IDX_W'(ETH_HDR)) begin
            if (ether_kind_ff == ET_ARP) begin
               if (idx == IDX_W'(ETH_HDR + 6) || idx == IDX_W'(ETH_HDR + 7)) begin
                  arp_oper_in = {arp_oper_ff[7:0], b};
               end else if (idx >= IDX_W'(ETH_HDR + 8) && idx <= IDX_W'(ETH_HDR + 13)) begin
                  sender_mac_in = {sender_mac_ff[39:0], b};
               end else if (idx >= IDX_W'(ETH_HDR + 14) && idx <= IDX_W'(ETH_HDR + 17)) begin
                  src_addr_in = {src_addr_ff[23:0], b};
               end else if (idx >= IDX_W'(ETH_HDR + 24) && idx <= IDX_W'(ETH_HDR + 27)) begin
                  target_ip_in = {target_ip_ff[23:0], b};
               end
            end else if (ether_kind_ff == ET_IPV4) begin
               if (idx == IDX_W'(ETH_HDR)) begin
                  header_len_in = {b[3:0], 2'b00};
               end else if (idx == IDX_W'(ETH_HDR + 9)) begin
                  ip_proto_in = b;
               end else if (idx >= IDX_W'(ETH_HDR + 12) && idx <= IDX_W'(ETH_HDR + 15)) begin
                  src_addr_in = {src_addr_ff[23:0], b};
               end else if (header_len_ff >= 6'(IP_MIN_HDR) && idx >= hdr_end) begin
                  if (u == IDX_W'(2) || u == IDX_W'(3)) begin
                     dst_port_in = {dst_port_ff[7:0], b};
                  end else if (u == IDX_W'(4) || u == IDX_W'(5)) begin
                     udp_len_in = {udp_len_ff[7:0], b};
                  end else if (u >= IDX_W'(UDP_HDR) && ip_proto_ff == PROTO_UDP &&
                               17'(payload_count_ff) < 17'(cap) &&
                               payload_count_ff < IDX_W'(MAX_FRAME)) begin
                     payload_hit      = 1'b1;
                     payload_count_in = payload_count_ff + IDX_W'(1);
                  end
               end
            end
         end
      end
   end

   // Results of this beat, judged on the updated frame state
   always_comb begin
      pay_rsp              = '0;
      pay_rsp.kind         = KIND_PAYLOAD;
      pay_rsp.payload_data = b;

      sum_rsp      = '0;
      sum_rsp.kind = KIND_IGNORED;
      sum_rsp.last = 1'b1;
      if (byte_index_in > IDX_W'(ETH_HDR)) begin
         if (ether_kind_in == ET_ARP &&
             byte_index_in >= IDX_W'(ETH_HDR + ARP_LEN)) begin
            sum_rsp.kind           = KIND_ARP;
            sum_rsp.source_ip      = src_addr_in;
            sum_rsp.arp_operation  = arp_oper_in;
            sum_rsp.arp_sender_mac = sender_mac_in;
            sum_rsp.arp_target_ip  = target_ip_in;
            sum_rsp.reply_needed   = (arp_oper_in == ARP_OP_REQUEST) &&
                                     (target_ip_in == local_ip_ff) &&
                                     (local_ip_ff != 32'd0);
         end else if (ether_kind_in == ET_IPV4 && header_len_in >= 6'(IP_MIN_HDR) &&
                      ip_proto_in == PROTO_UDP &&
                      byte_index_in >= IDX_W'(header_len_in) + IDX_W'(ETH_HDR + UDP_HDR)) begin
            sum_rsp.kind           = KIND_UDP;
            sum_rsp.udp_dest_port  = dst_port_in;
            sum_rsp.source_ip      = src_addr_in;
            sum_rsp.payload_length = 12'(payload_count_in);
         end
      end
   end

   always_comb begin
      push = '0;
      if (accept) begin
         if (payload_hit) begin
            push.first  = pay_rsp;
            push.second = sum_rsp;
            push.count  = req_data.frame_end ? 2'd2 : 2'd1;
         end else begin
            push.first = sum_rsp;
            push.count = req_data.frame_end ? 2'd1 : 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.frame_end)) begin
         byte_index_ff    <= '0;
         ether_kind_ff    <= '0;
         header_len_ff    <= '0;
         ip_proto_ff      <= '0;
         src_addr_ff      <= '0;
         dst_port_ff      <= '0;
         udp_len_ff       <= '0;
         arp_oper_ff      <= '0;
         sender_mac_ff    <= '0;
         target_ip_ff     <= '0;
         payload_count_ff <= '0;
      end else if (accept) begin
         byte_index_ff    <= byte_index_in;
         ether_kind_ff    <= ether_kind_in;
         header_len_ff    <= header_len_in;
         ip_proto_ff      <= ip_proto_in;
         src_addr_ff      <= src_addr_in;
         dst_port_ff      <= dst_port_in;
         udp_len_ff       <= udp_len_in;
         arp_oper_ff      <= arp_oper_in;
         sender_mac_ff    <= sender_mac_in;
         target_ip_ff     <= target_ip_in;
         payload_count_ff <= payload_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
      end else if (csr_wr_en) begin
         local_ip_ff <= csr_wr_data;
      end
   end

endmodule

[hdl/eaup_rsp_queue.sv]
// Result queue: takes up to two results per cycle, delivers one beat per cycle while rsp_stall is low.
module eaup_rsp_queue import eaup_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rsp_type          q_ff [QUEUE_DEPTH];
   rsp_type          q_in [QUEUE_DEPTH];
   rsp_type          shifted [QUEUE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] base_cnt;
   logic             pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = q_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   // leave room for a beat that yields two results
   assign full      = (count_ff > CNT_W'(QUEUE_DEPTH - 2));
   assign base_cnt  = count_ff - CNT_W'(pop);

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         shifted[i] = pop ? q_ff[i + 1] : q_ff[i];
      end
      shifted[QUEUE_DEPTH - 1] = q_ff[QUEUE_DEPTH - 1];

      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         q_in[i] = shifted[i];
         if (push.count != 2'd0 && CNT_W'(i) == base_cnt) begin
            q_in[i] = push.first;
         end
         if (push.count == 2'd2 && CNT_W'(i) == base_cnt + CNT_W'(1)) begin
            q_in[i] = push.second;
         end
      end
      count_in = base_cnt + CNT_W'(push.count);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

[hdl/eth_arp_udp_rx_parser.sv]
// Each result is registered in the result queue when its byte is accepted and is offered on rsp_ from the queue head.
// Throughput: one frame byte per cycle while req_stall is low; a frame-end beat that is
// also a payload byte yields two results.
// Byte acceptance stalls only while the four-entry result queue holds 3+ results.
// Reset: synchronous, active high; clears frame state, local_ip and the queue.
module eth_arp_udp_rx_parser import eaup_pkg::*; #(
   parameter int MAX_FRAME = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   push_type push;
   logic     accept;

   assign accept = req_valid && !req_stall;

   eaup_parser #(
      .MAX_FRAME (MAX_FRAME)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .push        (push)
   );

   eaup_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[hdl/eaup_checker.sv]
// Port-level checks for the receive parser, bound to the top level.
module eaup_checker import eaup_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result offered right after reset");

   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.kind == KIND_PAYLOAD) == !rsp_data.last))
      else $error("last flag does not match result kind");

   a_reply_arp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reply_needed |->
         rsp_data.kind == KIND_ARP && rsp_data.arp_operation == ARP_OP_REQUEST)
      else $error("reply flag on a non-request result");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty result queue");

endmodule

bind eth_arp_udp_rx_parser eaup_checker u_eaup_checker (.*);
